/* hdl/lcfa_pkg.sv */
// Shared types and constants for the leak and canister-full alarm block.
// No dependencies; used by every module in hdl/.
package lcfa_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] CFG_THERAPY_MODE   = 3'd0;
    localparam logic [2:0] CFG_LIMIT_MODE_A   = 3'd1;
    localparam logic [2:0] CFG_LIMIT_MODE_B   = 3'd2;
    localparam logic [2:0] CFG_LIMIT_DEFAULT  = 3'd3;
    localparam logic [2:0] CFG_CANCEL_TICKS   = 3'd4;
    localparam logic [2:0] CFG_SATURATE_LIMIT = 3'd5;
    localparam logic [2:0] CFG_WINDOW_TICKS   = 3'd6;
    localparam logic [2:0] CFG_PULSE_COUNT    = 3'd7;

    // Therapy mode codes; the unused code behaves as default
    localparam logic [1:0] MODE_DEFAULT = 2'd0;
    localparam logic [1:0] MODE_A       = 2'd1;
    localparam logic [1:0] MODE_B       = 2'd2;

    // Sub-mode codes of the second named mode
    localparam logic [1:0] SUB_PLAIN  = 2'd0;
    localparam logic [1:0] SUB_VALVED = 2'd1;

    localparam logic [15:0] CNT_MAX = 16'hFFFF;

    // Configuration register file
    typedef struct packed {
        logic [1:0]  therapy_mode;
        logic [15:0] leak_limit_mode_a;
        logic [15:0] leak_limit_mode_b;
        logic [15:0] leak_limit_default;
        logic [15:0] leak_cancel_ticks;
        logic [15:0] leak_saturate_limit;
        logic [15:0] full_window_ticks;
        logic [15:0] full_pulse_count;
    } t_cfg;

    // One input beat
    typedef struct packed {
        logic       check_enabled;
        logic       pump_running;
        logic       override_hold;
        logic [1:0] sub_mode;
        logic       valve_state;
        logic [3:0] canister_pulses;
    } t_item;

    // Saturating 16-bit increment
    function automatic logic [15:0] inc_sat16(input logic [15:0] v);
        return (v == CNT_MAX) ? CNT_MAX : v + 16'd1;
    endfunction

endpackage

/* hdl/leak_and_canister_full_alarm.sv */
// Top level of the leak and canister-full alarm block.
// Depends on lcfa_pkg, lcfa_leak and lcfa_canister.
//
// Each input beat is one supervision tick and yields exactly one result beat
// (leak alarm level and canister-full pulse). The block takes one beat per
// clock cycle sustained while the output is not stalled; a beat passes an
// input register, compare and increment logic that also updates the
// supervision state, and an output register, where its result is offered. While
// a result waits in the output register, the input register takes one more
// beat and then stalls the input.
// Configuration writes are always ready and must only be issued while no beat
// is in flight.
module leak_and_canister_full_alarm #(
    parameter int unsigned PRESCALE        = 10,
    parameter int unsigned SATURATE_MARGIN = 2200
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_check_enabled,
    input  logic        i_pump_running,
    input  logic        i_override_hold,
    input  logic [1:0]  i_sub_mode,
    input  logic        i_valve_state,
    input  logic [3:0]  i_canister_pulses,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_leak_alarm,
    output logic        o_canister_full,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    lcfa_pkg::t_cfg  r_cfg;
    lcfa_pkg::t_item r_item;
    logic            r_item_valid;
    logic            r_out_valid;
    logic            r_leak_alarm;
    logic            r_canister_full;

    logic step;
    logic in_accept;
    logic leak_flag;
    logic full_event;

    // Pipeline handshake
    assign step       = r_item_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_item_valid && !step;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.therapy_mode        <= lcfa_pkg::MODE_DEFAULT;
            r_cfg.leak_limit_mode_a   <= 16'd300;
            r_cfg.leak_limit_mode_b   <= 16'd300;
            r_cfg.leak_limit_default  <= 16'd300;
            r_cfg.leak_cancel_ticks   <= 16'd100;
            r_cfg.leak_saturate_limit <= 16'd1000;
            r_cfg.full_window_ticks   <= 16'd100;
            r_cfg.full_pulse_count    <= 16'd10;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lcfa_pkg::CFG_THERAPY_MODE:   r_cfg.therapy_mode        <= i_cfg_data[1:0];
                lcfa_pkg::CFG_LIMIT_MODE_A:   r_cfg.leak_limit_mode_a   <= i_cfg_data;
                lcfa_pkg::CFG_LIMIT_MODE_B:   r_cfg.leak_limit_mode_b   <= i_cfg_data;
                lcfa_pkg::CFG_LIMIT_DEFAULT:  r_cfg.leak_limit_default  <= i_cfg_data;
                lcfa_pkg::CFG_CANCEL_TICKS:   r_cfg.leak_cancel_ticks   <= i_cfg_data;
                lcfa_pkg::CFG_SATURATE_LIMIT: r_cfg.leak_saturate_limit <= i_cfg_data;
                lcfa_pkg::CFG_WINDOW_TICKS:   r_cfg.full_window_ticks   <= i_cfg_data;
                lcfa_pkg::CFG_PULSE_COUNT:    r_cfg.full_pulse_count    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_valid <= 1'b0;
        end else if (in_accept) begin
            r_item_valid <= 1'b1;
        end else if (step) begin
            r_item_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.check_enabled   <= i_check_enabled;
            r_item.pump_running    <= i_pump_running;
            r_item.override_hold   <= i_override_hold;
            r_item.sub_mode        <= i_sub_mode;
            r_item.valve_state     <= i_valve_state;
            r_item.canister_pulses <= i_canister_pulses;
        end
    end

    lcfa_leak #(
        .PRESCALE        (PRESCALE),
        .SATURATE_MARGIN (SATURATE_MARGIN)
    ) u_leak (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_item      (r_item),
        .i_cfg       (r_cfg),
        .o_leak_flag (leak_flag)
    );

    lcfa_canister u_canister (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_item       (r_item),
        .i_cfg        (r_cfg),
        .o_full_event (full_event)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_leak_alarm    <= leak_flag;
            r_canister_full <= full_event;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_leak_alarm    = r_leak_alarm;
    assign o_canister_full = r_canister_full;

endmodule

/* hdl/lcfa_leak.sv */
// Leak supervision: prescaler, idle cancel counter, leak timer and alarm flag.
// Depends on lcfa_pkg.
module lcfa_leak #(
    parameter int unsigned PRESCALE        = 10,
    parameter int unsigned SATURATE_MARGIN = 2200
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  lcfa_pkg::t_item i_item,
    input  lcfa_pkg::t_cfg  i_cfg,
    output logic            o_leak_flag
);

    localparam logic [7:0]  PRESCALE_LIM = 8'(PRESCALE);
    localparam logic [16:0] MARGIN       = 17'(SATURATE_MARGIN);

    logic [7:0]  r_prescale, n_prescale;
    logic [15:0] r_idle, n_idle;
    logic [15:0] r_timer, n_timer;
    logic        r_flag, n_flag;

    logic [15:0] mode_limit;
    logic [16:0] pin_sum;
    logic [15:0] pin_value;
    logic [15:0] timer_inc;

    // Limit chosen by therapy mode
    always_comb begin
        unique case (i_cfg.therapy_mode)
            lcfa_pkg::MODE_A: mode_limit = i_cfg.leak_limit_mode_a;
            lcfa_pkg::MODE_B: mode_limit = i_cfg.leak_limit_mode_b;
            default:          mode_limit = i_cfg.leak_limit_default;
        endcase
    end

    // Pin value: saturate limit plus margin, clamped to 16 bits
    assign pin_sum   = {1'b0, i_cfg.leak_saturate_limit} + MARGIN;
    assign pin_value = pin_sum[16] ? lcfa_pkg::CNT_MAX : pin_sum[15:0];
    assign timer_inc = lcfa_pkg::inc_sat16(r_timer);

    // Next leak state for this beat
    always_comb begin
        n_prescale = r_prescale;
        n_idle     = r_idle;
        n_timer    = r_timer;
        n_flag     = r_flag;
        if (i_item.check_enabled) begin
            if (!i_item.pump_running) begin
                n_prescale = '0;
                if (!i_item.override_hold) begin
                    if (r_idle >= i_cfg.leak_cancel_ticks) begin
                        n_idle  = '0;
                        n_flag  = 1'b0;
                        n_timer = '0;
                    end else begin
                        n_idle = r_idle + 16'd1;
                    end
                end
            end else begin
                n_idle = '0;
                if (r_prescale >= PRESCALE_LIM) begin
                    // prescaler fires: advance the timer
                    n_prescale = '0;
                    if (r_timer > i_cfg.leak_saturate_limit) begin
                        n_timer = pin_value;
                    end else begin
                        n_timer = timer_inc;
                        n_flag  = (timer_inc > mode_limit);
                    end
                end else begin
                    n_prescale = r_prescale + 8'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= '0;
            r_idle     <= '0;
            r_timer    <= '0;
            r_flag     <= 1'b0;
        end else if (i_step) begin
            r_prescale <= n_prescale;
            r_idle     <= n_idle;
            r_timer    <= n_timer;
            r_flag     <= n_flag;
        end
    end

    // Flag after this beat
    assign o_leak_flag = n_flag;

endmodule

/* hdl/lcfa_canister.sv */
// Canister pulse accumulation, window timing and qualified full event.
// Depends on lcfa_pkg.
module lcfa_canister (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_step,
    input  lcfa_pkg::t_item i_item,
    input  lcfa_pkg::t_cfg  i_cfg,
    output logic            o_full_event
);

    logic [15:0] r_pulse, n_pulse;
    logic [15:0] r_window, n_window;

    logic [16:0] pulse_sum;
    logic [15:0] pulse_acc;
    logic [15:0] window_inc;
    logic        qualified;

    // Saturating pulse accumulation
    assign pulse_sum  = {1'b0, r_pulse} + {13'd0, i_item.canister_pulses};
    assign pulse_acc  = pulse_sum[16] ? lcfa_pkg::CNT_MAX : pulse_sum[15:0];
    assign window_inc = lcfa_pkg::inc_sat16(r_window);

    // Sub-mode and valve qualification
    always_comb begin
        if (i_cfg.therapy_mode != lcfa_pkg::MODE_B) begin
            qualified = 1'b1;
        end else begin
            qualified = (i_item.sub_mode == lcfa_pkg::SUB_PLAIN) ||
                        ((i_item.sub_mode == lcfa_pkg::SUB_VALVED) && !i_item.valve_state);
        end
    end

    // Window check
    always_comb begin
        n_pulse      = pulse_acc;
        n_window     = window_inc;
        o_full_event = 1'b0;
        if (pulse_acc == '0) begin
            n_window = '0;
        end else if (window_inc <= i_cfg.full_window_ticks) begin
            if (pulse_acc > i_cfg.full_pulse_count) begin
                o_full_event = qualified;
                n_pulse      = '0;
                n_window     = '0;
            end
        end else begin
            n_pulse  = '0;
            n_window = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse  <= '0;
            r_window <= '0;
        end else if (i_step) begin
            r_pulse  <= n_pulse;
            r_window <= n_window;
        end
    end

endmodule

/* tb/leak_and_canister_full_alarm_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for leak_and_canister_full_alarm.
// Depends on lcfa_pkg and the block's RTL. A predictor class tracks the leak and
// canister state and checks every result beat in order against the block's output.
module leak_and_canister_full_alarm_test;

    localparam int unsigned PRESCALE        = 10;
    localparam int unsigned SATURATE_MARGIN = 2200;
    localparam int          CYCLE_LIMIT     = 300000;
    localparam int          ITEMS_PER_PHASE = 240;
    localparam int          HOLD_CYCLES     = 200;
    localparam int          DRAIN_CYCLES    = 6;

    // Codes the package leaves unnamed
    localparam logic [1:0] MODE_SPARE   = 2'd3;
    localparam logic [1:0] SUB_UNQUAL_A = 2'd2;
    localparam logic [1:0] SUB_UNQUAL_B = 2'd3;

    typedef struct packed {
        logic leak_alarm;
        logic canister_full;
    } t_alarm;

    // Tracks supervision state, predicts one result per tick, checks in order
    class alarm_predictor;
        lcfa_pkg::t_cfg cfg;
        logic [7:0]     prescale_cnt;
        logic [15:0]    idle_cnt;
        logic [15:0]    leak_timer;
        logic [15:0]    pulse_cnt;
        logic [15:0]    window_cnt;
        logic           leak_flag;
        t_alarm         expected_alarms[$];
        int             fails;

        function new();
            cfg.therapy_mode        = lcfa_pkg::MODE_DEFAULT;
            cfg.leak_limit_mode_a   = 16'd300;
            cfg.leak_limit_mode_b   = 16'd300;
            cfg.leak_limit_default  = 16'd300;
            cfg.leak_cancel_ticks   = 16'd100;
            cfg.leak_saturate_limit = 16'd1000;
            cfg.full_window_ticks   = 16'd100;
            cfg.full_pulse_count    = 16'd10;
            prescale_cnt = '0;
            idle_cnt     = '0;
            leak_timer   = '0;
            pulse_cnt    = '0;
            window_cnt   = '0;
            leak_flag    = 1'b0;
            fails        = 0;
        endfunction

        static function logic [15:0] bump16(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] data);
            case (idx)
                lcfa_pkg::CFG_THERAPY_MODE:   cfg.therapy_mode        = data[1:0];
                lcfa_pkg::CFG_LIMIT_MODE_A:   cfg.leak_limit_mode_a   = data;
                lcfa_pkg::CFG_LIMIT_MODE_B:   cfg.leak_limit_mode_b   = data;
                lcfa_pkg::CFG_LIMIT_DEFAULT:  cfg.leak_limit_default  = data;
                lcfa_pkg::CFG_CANCEL_TICKS:   cfg.leak_cancel_ticks   = data;
                lcfa_pkg::CFG_SATURATE_LIMIT: cfg.leak_saturate_limit = data;
                lcfa_pkg::CFG_WINDOW_TICKS:   cfg.full_window_ticks   = data;
                default:                      cfg.full_pulse_count    = data;
            endcase
        endfunction

        function void note_tick(lcfa_pkg::t_item it);
            logic [16:0] sum;
            logic [16:0] pin;
            logic [15:0] limit;
            t_alarm      res;
            sum = {1'b0, pulse_cnt} + {13'd0, it.canister_pulses};
            pulse_cnt = sum[16] ? 16'hFFFF : sum[15:0];
            case (cfg.therapy_mode)
                lcfa_pkg::MODE_A: limit = cfg.leak_limit_mode_a;
                lcfa_pkg::MODE_B: limit = cfg.leak_limit_mode_b;
                default:          limit = cfg.leak_limit_default;
            endcase
            pin = {1'b0, cfg.leak_saturate_limit} + 17'(SATURATE_MARGIN);
            res.canister_full = 1'b0;

            // leak supervision
            if (it.check_enabled) begin
                if (!it.pump_running) begin
                    prescale_cnt = '0;
                    if (!it.override_hold) begin
                        if (idle_cnt >= cfg.leak_cancel_ticks) begin
                            idle_cnt   = '0;
                            leak_flag  = 1'b0;
                            leak_timer = '0;
                        end else begin
                            idle_cnt = bump16(idle_cnt);
                        end
                    end
                end else begin
                    idle_cnt = '0;
                    if (prescale_cnt >= 8'(PRESCALE)) begin
                        prescale_cnt = '0;
                        // past the saturate limit the timer pins, alarm holds
                        if (leak_timer > cfg.leak_saturate_limit) begin
                            leak_timer = pin[16] ? 16'hFFFF : pin[15:0];
                        end else begin
                            leak_timer = bump16(leak_timer);
                            leak_flag  = (leak_timer > limit);
                        end
                    end else begin
                        prescale_cnt = prescale_cnt + 8'd1;
                    end
                end
            end

            // canister pulse window
            if (pulse_cnt == '0) begin
                window_cnt = '0;
            end else begin
                window_cnt = bump16(window_cnt);
                if (window_cnt <= cfg.full_window_ticks) begin
                    if (pulse_cnt > cfg.full_pulse_count) begin
                        res.canister_full = (cfg.therapy_mode != lcfa_pkg::MODE_B) ||
                                            (it.sub_mode == lcfa_pkg::SUB_PLAIN) ||
                                            (it.sub_mode == lcfa_pkg::SUB_VALVED &&
                                             !it.valve_state);
                        pulse_cnt  = '0;
                        window_cnt = '0;
                    end
                end else begin
                    pulse_cnt  = '0;
                    window_cnt = '0;
                end
            end
            res.leak_alarm = leak_flag;
            expected_alarms.push_back(res);
        endfunction

        function void check_alarm(logic leak_alarm, logic canister_full);
            t_alarm want;
            if (expected_alarms.size() == 0) begin
                $error("unexpected result beat: leak_alarm=%0b canister_full=%0b",
                       leak_alarm, canister_full);
                fails++;
                return;
            end
            want = expected_alarms.pop_front();
            if (leak_alarm !== want.leak_alarm) begin
                $error("leak_alarm: expected %0b, actual %0b", want.leak_alarm, leak_alarm);
                fails++;
            end
            if (canister_full !== want.canister_full) begin
                $error("canister_full: expected %0b, actual %0b",
                       want.canister_full, canister_full);
                fails++;
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_check_enabled;
    logic        i_pump_running;
    logic        i_override_hold;
    logic [1:0]  i_sub_mode;
    logic        i_valve_state;
    logic [3:0]  i_canister_pulses;
    logic        o_out_valid;
    logic        i_out_stall;
    logic        o_leak_alarm;
    logic        o_canister_full;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    lcfa_pkg::t_item tick_now;
    alarm_predictor  predictor = new();
    int              send_idle_pct = 0;
    int              stall_pct     = 0;
    int              hold_requests = 0;
    bit              pump_on       = 1'b1;

    assign tick_now = {i_check_enabled, i_pump_running, i_override_hold,
                       i_sub_mode, i_valve_state, i_canister_pulses};

    leak_and_canister_full_alarm #(
        .PRESCALE        (PRESCALE),
        .SATURATE_MARGIN (SATURATE_MARGIN)
    ) i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_check_enabled   (i_check_enabled),
        .i_pump_running    (i_pump_running),
        .i_override_hold   (i_override_hold),
        .i_sub_mode        (i_sub_mode),
        .i_valve_state     (i_valve_state),
        .i_canister_pulses (i_canister_pulses),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_leak_alarm      (o_leak_alarm),
        .o_canister_full   (o_canister_full),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Monitor: values read here are the ones settled before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) predictor.write_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall) predictor.note_tick(tick_now);
            if (o_out_valid && !i_out_stall) predictor.check_alarm(o_leak_alarm, o_canister_full);
        end
    end

    // Output side: random stall, plus a long hold-off on request
    initial begin : out_side
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Run limit
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    function automatic lcfa_pkg::t_item mk_tick(logic en, logic pump, logic hold,
                                                logic [1:0] sub, logic valve,
                                                logic [3:0] pulses);
        return {en, pump, hold, sub, valve, pulses};
    endfunction

    // One input beat, with random idle cycles ahead of it
    task automatic send_tick(input lcfa_pkg::t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        {i_check_enabled, i_pump_running, i_override_hold,
         i_sub_mode, i_valve_state, i_canister_pulses} <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic load_config(input logic [1:0] mode, input logic [15:0] lim_a,
                               input logic [15:0] lim_b, input logic [15:0] lim_def,
                               input logic [15:0] cancel, input logic [15:0] sat,
                               input logic [15:0] window, input logic [15:0] thresh);
        write_reg(lcfa_pkg::CFG_THERAPY_MODE, {14'd0, mode});
        write_reg(lcfa_pkg::CFG_LIMIT_MODE_A, lim_a);
        write_reg(lcfa_pkg::CFG_LIMIT_MODE_B, lim_b);
        write_reg(lcfa_pkg::CFG_LIMIT_DEFAULT, lim_def);
        write_reg(lcfa_pkg::CFG_CANCEL_TICKS, cancel);
        write_reg(lcfa_pkg::CFG_SATURATE_LIMIT, sat);
        write_reg(lcfa_pkg::CFG_WINDOW_TICKS, window);
        write_reg(lcfa_pkg::CFG_PULSE_COUNT, thresh);
        i_cfg_valid <= 1'b0;
    endtask

    // Pump state runs in long stretches so the prescaler and timers get exercised
    task automatic run_random(input int n);
        lcfa_pkg::t_item it;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(15) == 0) pump_on = !pump_on;
            it.check_enabled   = ($urandom_range(9) != 0);
            it.pump_running    = pump_on;
            it.override_hold   = ($urandom_range(4) == 0);
            it.sub_mode        = 2'($urandom_range(3));
            it.valve_state     = 1'($urandom_range(1));
            it.canister_pulses = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(15));
            send_tick(it);
        end
    endtask

    // Wait until every expected beat is back, then let the pipe settle
    task automatic finish_phase();
        i_in_valid <= 1'b0;
        while (predictor.expected_alarms.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin : main_seq
        i_rst_n           <= 1'b0;
        i_in_valid        <= 1'b0;
        i_check_enabled   <= 1'b0;
        i_pump_running    <= 1'b0;
        i_override_hold   <= 1'b0;
        i_sub_mode        <= lcfa_pkg::SUB_PLAIN;
        i_valve_state     <= 1'b0;
        i_canister_pulses <= 4'd0;
        i_cfg_valid       <= 1'b0;
        i_cfg_index       <= lcfa_pkg::CFG_THERAPY_MODE;
        i_cfg_data        <= 16'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: tiny limits so one firing raises the alarm
        load_config(lcfa_pkg::MODE_B, 16'd300, 16'd0, 16'd300, 16'd2, 16'd3, 16'd4, 16'd5);
        send_tick(mk_tick(1'b0, 1'b0, 1'b0, lcfa_pkg::SUB_PLAIN, 1'b0, 4'd0));
        // qualification by sub-mode and valve
        send_tick(mk_tick(1'b1, 1'b1, 1'b0, lcfa_pkg::SUB_PLAIN, 1'b0, 4'd15));
        send_tick(mk_tick(1'b1, 1'b1, 1'b0, lcfa_pkg::SUB_VALVED, 1'b1, 4'd15));
        send_tick(mk_tick(1'b1, 1'b1, 1'b0, lcfa_pkg::SUB_VALVED, 1'b0, 4'd15));
        send_tick(mk_tick(1'b1, 1'b1, 1'b0, SUB_UNQUAL_A, 1'b0, 4'd15));
        send_tick(mk_tick(1'b1, 1'b1, 1'b1, SUB_UNQUAL_B, 1'b1, 4'd15));
        // pump run up to the first prescaler firing
        repeat (7) send_tick(mk_tick(1'b1, 1'b1, 1'b0, lcfa_pkg::SUB_PLAIN, 1'b0, 4'd0));
        // checking disabled, then override hold, then idle cancel
        send_tick(mk_tick(1'b0, 1'b0, 1'b0, lcfa_pkg::SUB_PLAIN, 1'b0, 4'd0));
        repeat (2) send_tick(mk_tick(1'b1, 1'b0, 1'b1, lcfa_pkg::SUB_PLAIN, 1'b0, 4'd0));
        repeat (3) send_tick(mk_tick(1'b1, 1'b0, 1'b0, lcfa_pkg::SUB_PLAIN, 1'b0, 4'd0));
        send_tick(mk_tick(1'b1, 1'b1, 1'b1, SUB_UNQUAL_B, 1'b1, 4'd15));
        // slow pulses run out of window
        repeat (5) send_tick(mk_tick(1'b1, 1'b1, 1'b0, lcfa_pkg::SUB_PLAIN, 1'b0, 4'd1));
        finish_phase();

        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 68; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 68; end
                default: begin send_idle_pct = 13; stall_pct = 13; end
            endcase
            case (p)
                0: load_config(lcfa_pkg::MODE_DEFAULT, 16'd300, 16'd300, 16'd300,
                               16'd100, 16'd1000, 16'd100, 16'd10);
                1: load_config(lcfa_pkg::MODE_A, 16'd3, 16'hFFFF, 16'hFFFF,
                               16'd5, 16'd8, 16'd20, 16'd30);
                2: load_config(lcfa_pkg::MODE_B, 16'd0, 16'd0, 16'd0,
                               16'd0, 16'd0, 16'd0, 16'd0);
                3: load_config(lcfa_pkg::MODE_B, 16'd7, 16'd10, 16'd2,
                               16'd40, 16'd20, 16'd5, 16'd12);
                4: load_config(MODE_SPARE, 16'hFFFF, 16'hFFFF, 16'd4,
                               16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                5: load_config(lcfa_pkg::MODE_DEFAULT, 16'd1, 16'd1, 16'hFFFF,
                               16'd10, 16'd63000, 16'd3, 16'd5);
                6: load_config(lcfa_pkg::MODE_A, 16'd0, 16'd6, 16'd1,
                               16'd2, 16'd2, 16'd50, 16'd40);
                default: load_config(lcfa_pkg::MODE_B, 16'd2, 16'd6, 16'd1,
                                     16'd12, 16'd3, 16'd8, 16'd9);
            endcase
            // long output hold-off while input keeps coming
            if (p == 4) hold_requests++;
            run_random(ITEMS_PER_PHASE);
            finish_phase();
        end

        if (predictor.fails == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
hdl/lcfa_pkg.sv
hdl/lcfa_leak.sv
hdl/lcfa_canister.sv
hdl/leak_and_canister_full_alarm.sv
tb/leak_and_canister_full_alarm_test.sv
